// ===== rtl/psob_pkg.sv =====
// Package for the odd-number Atkin sieve: widths, unit mode codes, the
// result struct of the shared arithmetic unit and small residue helpers.
// No dependencies.
`default_nettype none

package psob_pkg;

    localparam int LIM_W         = 8;   // request limit width
    localparam int MASK_W        = 47;  // result bitmap width
    localparam int OP_W          = 4;   // x, y and p operands (all stay below 14)
    localparam int SQ_W          = 8;   // square of an operand
    localparam int IDX_MAX_W     = 6;   // table index, table never exceeds 64 entries
    localparam int MAX_LIMIT_DEF = 100;

    // shared unit modes
    localparam logic [1:0] MODE_A   = 2'd0;  // 4x^2 + y^2
    localparam logic [1:0] MODE_B   = 2'd1;  // 3x^2 + y^2
    localparam logic [1:0] MODE_C   = 2'd2;  // 3x^2 - y^2, x > y
    localparam logic [1:0] MODE_CLR = 2'd3;  // square-multiple clear

    typedef struct packed {
        logic                 hit;      // table entry to be toggled / cleared
        logic                 xx_over;  // a*a above limit
        logic                 yy_over;  // b*b above limit
        logic [SQ_W-1:0]      xx;       // a*a
        logic [IDX_MAX_W-1:0] idx;      // table index of n
    } unit_res_t;

    // square of v, mod 12
    function automatic logic [3:0] sq_mod12(input logic [OP_W-1:0] v);
        logic [3:0] r;
        case (v)
            4'd0, 4'd6, 4'd12:               r = 4'd0;
            4'd1, 4'd5, 4'd7, 4'd11, 4'd13:  r = 4'd1;
            4'd2, 4'd4, 4'd8, 4'd10, 4'd14:  r = 4'd4;
            4'd3, 4'd9, 4'd15:               r = 4'd9;
            default:                         r = 4'd0;
        endcase
        return r;
    endfunction

    // v mod 12 for v below 64, three compare-subtract steps
    function automatic logic [3:0] mod12_6(input logic [5:0] v);
        logic [5:0] t;
        t = v;
        if (t >= 6'd48)
            t = t - 6'd48;
        if (t >= 6'd24)
            t = t - 6'd24;
        if (t >= 6'd12)
            t = t - 6'd12;
        return t[3:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/psob_form_unit.sv =====
// Shared arithmetic unit: forms one quadratic value or takes a clear address,
// checks the mod-12 rule, range and table index. Uses psob_pkg.
`default_nettype none

module psob_form_unit
    import psob_pkg::*;
#(
    parameter int MAX_LIMIT = MAX_LIMIT_DEF
)
(
    input  wire logic [1:0]                           mode,
    input  wire logic [OP_W-1:0]                      a,
    input  wire logic [OP_W-1:0]                      b,
    input  wire logic [$clog2(5*MAX_LIMIT+1)-1:0]     m,
    input  wire logic [LIM_W-1:0]                     lim,
    output unit_res_t                                 res
);

    localparam int TBL_SIZE = (MAX_LIMIT - 5) / 2;
    localparam int N_W      = $clog2(5*MAX_LIMIT+1);
    localparam int CMP_W    = (N_W > LIM_W) ? N_W : LIM_W;

    logic [SQ_W-1:0]  xx;
    logic [SQ_W-1:0]  yy;
    logic [N_W-1:0]   xx_n;
    logic [N_W-1:0]   yy_n;
    logic [3:0]       am;
    logic [3:0]       bm;
    logic [3:0]       r12;
    logic [N_W-1:0]   n;
    logic             rule_ok;
    logic             in_range;
    logic [N_W-1:0]   idx_full;
    logic             idx_ok;

    always_comb
    begin
        xx   = {{(SQ_W-OP_W){1'b0}}, a} * {{(SQ_W-OP_W){1'b0}}, a};
        yy   = {{(SQ_W-OP_W){1'b0}}, b} * {{(SQ_W-OP_W){1'b0}}, b};
        xx_n = N_W'(xx);
        yy_n = N_W'(yy);
        am   = sq_mod12(a);
        bm   = sq_mod12(b);
        r12  = 4'd0;
        n    = m;
        rule_ok = 1'b0;
        case (mode)
            MODE_A:
            begin
                n       = (xx_n << 2) + yy_n;
                r12     = mod12_6({am, 2'b00} + 6'(bm));
                rule_ok = (r12 == 4'd1) || (r12 == 4'd5);
            end
            MODE_B:
            begin
                n       = (xx_n << 1) + xx_n + yy_n;
                r12     = mod12_6(6'(am) + {1'b0, am, 1'b0} + 6'(bm));
                rule_ok = (r12 == 4'd7);
            end
            MODE_C:
            begin
                n       = (xx_n << 1) + xx_n - yy_n;
                r12     = mod12_6(6'(am) + {1'b0, am, 1'b0} + 6'd12 - 6'(bm));
                rule_ok = (a > b) && (r12 == 4'd11);
            end
            MODE_CLR:
            begin
                n       = m;
                rule_ok = 1'b1;
            end
            default:
            begin
                n       = m;
                rule_ok = 1'b0;
            end
        endcase
        in_range = (n >= N_W'(7)) && (CMP_W'(n) <= CMP_W'(lim));
        idx_full = (n - N_W'(7)) >> 1;
        idx_ok   = (idx_full < N_W'(TBL_SIZE));

        res.hit     = rule_ok && in_range && idx_ok;
        res.xx_over = (xx > lim);
        res.yy_over = (yy > lim);
        res.xx      = xx;
        res.idx     = IDX_MAX_W'(idx_full);
    end

endmodule

`default_nettype wire

// ===== rtl/prime_sieve_odd_bitmap.sv =====
// Sequence: each (x, y) pair with x*x, y*y <= limit passes through S_FA, S_FB and S_FC,
// with a further S_FA step at the end of each row and at the end of the scan; then S_SQSEL
// visits each square candidate, S_CLR clears each multiple and closes each clearing run,
// and S_FIN loads the result. An over-limit request goes straight to S_FIN. One request at
// a time; the next is taken the cycle after the load. The result sits
// in an output register so the next request is taken while it waits.
// Reset: asynchronous, active low; sequencer idle, no result pending.
`default_nettype none

module prime_sieve_odd_bitmap
    import psob_pkg::*;
#(
    parameter int MAX_LIMIT = MAX_LIMIT_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire logic [LIM_W-1:0]  limit,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output logic [MASK_W-1:0]      prime_mask,
    output logic                   limit_error
);

    localparam int TBL_SIZE = (MAX_LIMIT - 5) / 2;
    localparam int IDX_W    = (TBL_SIZE > 1) ? $clog2(TBL_SIZE) : 1;
    localparam int N_W      = $clog2(5*MAX_LIMIT+1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FA    = 3'd1;
    localparam logic [2:0] S_FB    = 3'd2;
    localparam logic [2:0] S_FC    = 3'd3;
    localparam logic [2:0] S_SQSEL = 3'd4;
    localparam logic [2:0] S_CLR   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic                res_valid_reg, res_valid_next;
    logic [TBL_SIZE-1:0] tbl_reg, tbl_next;
    logic [OP_W-1:0]     x_reg, x_next;
    logic [OP_W-1:0]     y_reg, y_next;
    logic [OP_W-1:0]     p_reg, p_next;
    logic [N_W-1:0]      m_reg, m_next;
    logic [SQ_W-1:0]     sq_reg, sq_next;
    logic [LIM_W-1:0]    lim_reg, lim_next;
    logic                err_reg, err_next;
    logic [MASK_W-1:0]   mask_reg, mask_next;
    logic                lerr_reg, lerr_next;

    logic [1:0]          mode;
    logic [OP_W-1:0]     op_a;
    unit_res_t           ures;
    logic [IDX_W-1:0]    hit_idx;
    logic [OP_W-1:0]     r_full;
    logic [IDX_W-1:0]    r_idx;
    logic                p_in_tbl;
    logic                req_acc;
    logic                load_res;
    logic [MASK_W-1:0]   mask_w;

    genvar gi;
    generate
        for (gi = 0; gi < MASK_W; gi++)
        begin : g_mask
            if (gi < TBL_SIZE)
            begin : g_on
                assign mask_w[gi] = tbl_reg[gi];
            end
            else
            begin : g_off
                assign mask_w[gi] = 1'b0;
            end
        end
    endgenerate

    always_comb
    begin
        case (state_reg)
            S_FA:     mode = MODE_A;
            S_FB:     mode = MODE_B;
            S_FC:     mode = MODE_C;
            default:  mode = MODE_CLR;
        endcase
        op_a = (state_reg == S_SQSEL) ? p_reg : x_reg;
    end

    psob_form_unit #(
        .MAX_LIMIT (MAX_LIMIT)
    ) u_form (
        .mode (mode),
        .a    (op_a),
        .b    (y_reg),
        .m    (m_reg),
        .lim  (lim_reg),
        .res  (ures)
    );

    assign hit_idx   = ures.idx[IDX_W-1:0];
    assign r_full    = (p_reg - OP_W'(7)) >> 1;
    assign r_idx     = IDX_W'(r_full);
    assign p_in_tbl  = (p_reg >= OP_W'(7)) && (int'(r_full) < TBL_SIZE) && tbl_reg[r_idx];
    assign req_stall = (state_reg != S_IDLE);
    assign req_acc   = req_valid && !req_stall;
    assign load_res  = (state_reg == S_FIN) && (!res_valid_reg || !res_stall);

    always_comb
    begin
        state_next     = state_reg;
        tbl_next       = tbl_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        p_next         = p_reg;
        m_next         = m_reg;
        sq_next        = sq_reg;
        lim_next       = lim_reg;
        err_next       = err_reg;
        mask_next      = mask_reg;
        lerr_next      = lerr_reg;
        res_valid_next = res_valid_reg;

        if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    lim_next = limit;
                    tbl_next = '0;
                    x_next   = OP_W'(1);
                    y_next   = OP_W'(1);
                    if (limit > LIM_W'(MAX_LIMIT))
                    begin
                        err_next   = 1'b1;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        err_next   = 1'b0;
                        state_next = S_FA;
                    end
                end
            end
            S_FA:
            begin
                if (ures.xx_over)
                begin
                    p_next     = OP_W'(5);
                    state_next = S_SQSEL;
                end
                else if (ures.yy_over)
                begin
                    x_next = x_reg + OP_W'(1);
                    y_next = OP_W'(1);
                end
                else
                begin
                    if (ures.hit)
                        tbl_next[hit_idx] = ~tbl_reg[hit_idx];
                    state_next = S_FB;
                end
            end
            S_FB:
            begin
                if (ures.hit)
                    tbl_next[hit_idx] = ~tbl_reg[hit_idx];
                state_next = S_FC;
            end
            S_FC:
            begin
                if (ures.hit)
                    tbl_next[hit_idx] = ~tbl_reg[hit_idx];
                y_next     = y_reg + OP_W'(1);
                state_next = S_FA;
            end
            S_SQSEL:
            begin
                // five is cleared unconditionally, later p only if still marked
                if (ures.xx_over)
                    state_next = S_FIN;
                else if ((p_reg == OP_W'(5)) || p_in_tbl)
                begin
                    sq_next    = ures.xx;
                    m_next     = N_W'(ures.xx);
                    state_next = S_CLR;
                end
                else
                    p_next = p_reg + OP_W'(2);
            end
            S_CLR:
            begin
                if (ures.hit)
                begin
                    tbl_next[hit_idx] = 1'b0;
                    m_next = m_reg + N_W'({sq_reg, 1'b0});
                end
                else
                begin
                    p_next     = p_reg + OP_W'(2);
                    state_next = S_SQSEL;
                end
            end
            S_FIN:
            begin
                if (load_res)
                begin
                    mask_next      = mask_w;
                    lerr_next      = err_reg;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tbl_reg  <= tbl_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        p_reg    <= p_next;
        m_reg    <= m_next;
        sq_reg   <= sq_next;
        lim_reg  <= lim_next;
        err_reg  <= err_next;
        mask_reg <= mask_next;
        lerr_reg <= lerr_next;
    end

    assign res_valid   = res_valid_reg;
    assign prime_mask  = mask_reg;
    assign limit_error = lerr_reg;

endmodule

`default_nettype wire

// ===== rtl/psob_checker.sv =====
// Port-level checks for prime_sieve_odd_bitmap, bound to the top level.
// Uses psob_pkg.
`default_nettype none

module psob_checker
    import psob_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire logic              req_stall,
    input  wire logic [LIM_W-1:0]  limit,
    input  wire logic              res_valid,
    input  wire logic              res_stall,
    input  wire logic [MASK_W-1:0] prime_mask,
    input  wire logic              limit_error
);

    // a held request beat stays up with its limit
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(limit))
        else $error("request beat changed while stalled");

    // a held result beat stays up
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result beat dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(prime_mask) && $stable(limit_error))
        else $error("result payload changed while stalled");

    // an error result never carries primes
    a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && limit_error |-> prime_mask == '0)
        else $error("mask not empty on limit error");

    // busy for at least the cycle after taking a request
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request side ready straight after a beat");

endmodule

bind prime_sieve_odd_bitmap psob_checker u_psob_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .limit       (limit),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .prime_mask  (prime_mask),
    .limit_error (limit_error)
);

`default_nettype wire

// ===== tb/prime_map_checker.sv =====
`timescale 1ns / 100ps
// Checker for prime_sieve_odd_bitmap: watches the request and result channels,
// predicts each odd-prime bitmap from the beat's limit and compares field by field.
// Depends on psob_pkg for field widths.
module prime_map_checker
    import psob_pkg::*;
#(
    parameter int MAX_LIMIT = MAX_LIMIT_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire logic              req_stall,
    input  wire logic [LIM_W-1:0]  limit,
    input  wire logic              res_valid,
    input  wire logic              res_stall,
    input  wire logic [MASK_W-1:0] prime_mask,
    input  wire logic              limit_error,
    output int                     miss_count,
    output int                     maps_owed
);

    localparam int CAND_N = (MAX_LIMIT - 5) / 2 > 0 ? (MAX_LIMIT - 5) / 2 : 1;

    typedef struct packed {
        logic [LIM_W-1:0]  lim;
        logic [MASK_W-1:0] mask;
        logic              err;
    } prime_map_t;

    prime_map_t owed_maps[$];
    bit         cand [CAND_N];   // entry r stands for 2r+7

    function automatic void flip_cand(input int n, input int lim);
        if (n >= 7 && n <= lim && (n - 7) / 2 < CAND_N)
            cand[(n - 7) / 2] = !cand[(n - 7) / 2];
    endfunction

    // odd multiples of p*p only
    function automatic void strike_squares(input int p, input int lim);
        int m;
        for (m = p * p; m <= lim; m += 2 * p * p)
            if ((m - 7) / 2 < CAND_N)
                cand[(m - 7) / 2] = 1'b0;
    endfunction

    function automatic prime_map_t atkin_odd_map(input logic [LIM_W-1:0] lim_in);
        prime_map_t res;
        int         lim;
        int         x;
        int         y;
        int         n;
        int         r;
        res = '0;
        res.lim = lim_in;
        lim = int'(lim_in);
        foreach (cand[i])
            cand[i] = 1'b0;
        if (lim > MAX_LIMIT)
        begin
            res.err = 1'b1;
            return res;
        end
        for (x = 1; x * x <= lim; x++)
        begin
            for (y = 1; y * y <= lim; y++)
            begin
                n = 4 * x * x + y * y;
                if (n % 12 == 1 || n % 12 == 5)
                    flip_cand(n, lim);
                n = 3 * x * x + y * y;
                if (n % 12 == 7)
                    flip_cand(n, lim);
                if (x > y)
                begin
                    n = 3 * x * x - y * y;
                    if (n % 12 == 11)
                        flip_cand(n, lim);
                end
            end
        end
        // 25 is struck although 5 never sits in the table
        strike_squares(5, lim);
        for (r = 0; r < CAND_N && (2 * r + 7) * (2 * r + 7) <= lim; r++)
            if (cand[r])
                strike_squares(2 * r + 7, lim);
        for (r = 0; r < CAND_N && r < MASK_W; r++)
            if (cand[r] && 2 * r + 7 <= lim)
                res.mask[r] = 1'b1;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        miss_count++;
        $display("%0t ns: prime map check: %s", $time, what);
    endtask

    always @(posedge clk)
    begin : watch
        prime_map_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (owed_maps.size() == 0)
                    report_mismatch($sformatf("result beat with none pending, mask %h err %b",
                                              prime_mask, limit_error));
                else
                begin
                    want = owed_maps.pop_front();
                    if (prime_mask !== want.mask)
                        report_mismatch($sformatf("limit %0d: prime_mask %h, want %h",
                                                  want.lim, prime_mask, want.mask));
                    if (limit_error !== want.err)
                        report_mismatch($sformatf("limit %0d: limit_error %b, want %b",
                                                  want.lim, limit_error, want.err));
                end
            end
            if (req_valid && !req_stall)
                owed_maps.push_back(atkin_odd_map(limit));
            maps_owed = owed_maps.size();
        end
    end

endmodule

// ===== tb/prime_sieve_odd_bitmap_test.sv =====
`timescale 1ns / 100ps
// Top of the prime_sieve_odd_bitmap bench: clock, reset, limit beats with random
// gaps, random result stalls, watchdog and verdict. Checking sits in prime_map_checker.
// Depends on psob_pkg, prime_sieve_odd_bitmap and prime_map_checker.
module prime_sieve_odd_bitmap_test;
    import psob_pkg::*;

    localparam int ITEMS        = 1200;
    localparam int CALM_ITEMS   = 150;   // tail of the run with no idling
    localparam int STUCK_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 400;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    logic [LIM_W-1:0]  limit;
    logic              res_valid;
    logic              res_stall;
    logic [MASK_W-1:0] prime_mask;
    logic              limit_error;
    int                miss_count;
    int                maps_owed;
    int                stuck_cycles;
    bit                calm;

    prime_sieve_odd_bitmap uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .limit       (limit),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .prime_mask  (prime_mask),
        .limit_error (limit_error)
    );

    prime_map_checker chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .limit       (limit),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .prime_mask  (prime_mask),
        .limit_error (limit_error),
        .miss_count  (miss_count),
        .maps_owed   (maps_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly in-range limits, where the sieve does real work
    function automatic logic [LIM_W-1:0] pick_limit();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7)
            return LIM_W'($urandom_range(0, MAX_LIMIT_DEF));
        else if (roll < 8)
            return LIM_W'($urandom_range(MAX_LIMIT_DEF + 1, 255));
        else
            return LIM_W'($urandom_range(0, 255));
    endfunction

    task automatic send_limit(input logic [LIM_W-1:0] v);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        req_valid <= 1'b1;
        limit     <= v;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        logic [LIM_W-1:0] corner_limits [$] = '{8'd0, 8'd1, 8'd2, 8'd5, 8'd6, 8'd7,
            8'd8, 8'd9, 8'd11, 8'd13, 8'd24, 8'd25, 8'd26, 8'd48, 8'd49, 8'd50,
            8'd75, 8'd99, 8'd100, 8'd101, 8'd102, 8'd133, 8'd200, 8'd254, 8'd255};
        rst_n     = 1'b0;
        req_valid = 1'b0;
        limit     = '0;
        calm      = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (corner_limits[i])
            send_limit(corner_limits[i]);
        for (int i = 0; i < ITEMS; i++)
        begin
            calm = (i >= ITEMS - CALM_ITEMS);
            send_limit(pick_limit());
        end
        req_valid <= 1'b0;
        wait (maps_owed == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (miss_count == 0)
            $display("prime_sieve_odd_bitmap: match");
        else
            $display("prime_sieve_odd_bitmap: mismatch");
        $finish;
    end

    // result-side back-pressure in bursts
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (res_valid && !res_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("prime_sieve_odd_bitmap: mismatch");
            $finish;
        end
    end

endmodule
